[hdl/tcs_pkg.sv]
`default_nettype none

package tcs_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [7:0]  pos_t;
	typedef logic [15:0] term_t;

	localparam logic [16:0] MOD_M        = 17'd65535;
	localparam logic [16:0] WRAP_ONE     = 17'h10000;
	localparam term_t       FIRST_OFFSET = 16'd7;
	localparam term_t       TERM_INIT    = 16'd1;
	localparam pos_t        POS_INIT     = 8'd0;
	localparam pos_t        POS_SECOND   = 8'd1;

endpackage

`default_nettype wire

[hdl/tcs_term_unit.sv]
`default_nettype none

module tcs_term_unit (
	input  wire tcs_pkg::byte_t data_byte,
	input  wire tcs_pkg::pos_t  position,
	input  wire tcs_pkg::term_t older_term,
	input  wire tcs_pkg::term_t newer_term,
	input  wire logic           first,
	output tcs_pkg::term_t      next_term
);
	import tcs_pkg::*;

	logic [7:0]  alpha;
	logic [7:0]  beta;
	logic [8:0]  coef;
	logic [24:0] prod;
	logic [24:0] sub;
	logic        no_borrow;
	logic [24:0] diff;
	logic [16:0] folded;
	logic [16:0] reduced;
	logic [16:0] wrapped;
	logic [16:0] neg_term;
	term_t       rec_term;

	// alpha is 17 times the position and beta is 31 times it, both mod 256.
	assign alpha = position + {position[3:0], 4'b0000};
	assign beta  = {position[2:0], 5'b00000} - position;
	assign coef  = {1'b0, data_byte} + {1'b0, alpha};

	assign prod = {9'b0, newer_term} * {16'b0, coef};
	assign sub  = {1'b0, {8'b0, older_term} * {16'b0, beta}};

	assign no_borrow = prod >= sub;
	assign diff      = no_borrow ? (prod - sub) : (sub - prod);

	// 2^16 is 1 mod 65535, so the upper bits fold onto the lower ones.
	assign folded  = {8'b0, diff[24:16]} + {1'b0, diff[15:0]};
	assign reduced = (folded >= MOD_M) ? (folded - MOD_M) : folded;

	// A borrow in 64-bit arithmetic leaves one plus the negated distance.
	assign wrapped  = WRAP_ONE - reduced;
	assign neg_term = (wrapped >= MOD_M) ? (wrapped - MOD_M) : wrapped;

	assign rec_term  = no_borrow ? reduced[15:0] : neg_term[15:0];
	assign next_term = first ? ({8'b0, data_byte} + FIRST_OFFSET) : rec_term;

endmodule

`default_nettype wire

[hdl/three_term_recurrence_checksum_core.sv]
`default_nettype none

// Three-term recurrence checksum. Message bytes arrive on the data channel,
// one per transfer, with final_byte set on the last byte of each message; one
// 16-bit checksum (0 to 65534) leaves on the checksum channel per message.
// The core takes one byte every clock cycle without gaps, also while a
// checksum waits to be taken, as long as no second checksum would be needed
// before the first is taken. A byte is registered on input and the next term
// is formed in the following cycle; the final byte's term is loaded into the
// checksum register, which presents it, once that register is free. The rate
// is set by the term recurrence: the multiply, subtract and fold by 65535
// close a loop through the term registers. State returns to its start values
// after every final byte.
module three_term_recurrence_checksum_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 data_valid,
	output logic                data_ready,
	input  wire tcs_pkg::byte_t data_byte,
	input  wire logic           final_byte,
	output logic                checksum_valid,
	input  wire                 checksum_ready,
	output tcs_pkg::term_t      checksum
);
	import tcs_pkg::*;

	logic  valid_s1;
	byte_t byte_s1;
	logic  final_s1;
	logic  advance;
	logic  out_free;

	term_t older_q;
	term_t newer_q;
	pos_t  position_q;
	logic  awaiting_first_q;
	term_t next_term;

	logic  checksum_valid_q;
	term_t checksum_q;

	assign out_free   = !checksum_valid_q || checksum_ready;
	assign advance    = valid_s1 && (!final_s1 || out_free);
	assign data_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			byte_s1  <= data_byte;
			final_s1 <= final_byte;
		end
	end

	tcs_term_unit u_term (
		.data_byte  (byte_s1),
		.position   (position_q),
		.older_term (older_q),
		.newer_term (newer_q),
		.first      (awaiting_first_q),
		.next_term  (next_term)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q          <= TERM_INIT;
			newer_q          <= TERM_INIT;
			position_q       <= POS_INIT;
			awaiting_first_q <= 1'b1;
		end else if (advance) begin
			if (final_s1) begin
				older_q          <= TERM_INIT;
				newer_q          <= TERM_INIT;
				position_q       <= POS_INIT;
				awaiting_first_q <= 1'b1;
			end else if (awaiting_first_q) begin
				older_q          <= TERM_INIT;
				newer_q          <= next_term;
				position_q       <= POS_SECOND;
				awaiting_first_q <= 1'b0;
			end else begin
				older_q    <= newer_q;
				newer_q    <= next_term;
				position_q <= position_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checksum_valid_q <= 1'b0;
		end else if (advance && final_s1) begin
			checksum_valid_q <= 1'b1;
		end else if (checksum_ready) begin
			checksum_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			checksum_q <= next_term;
		end
	end

	assign checksum_valid = checksum_valid_q;
	assign checksum       = checksum_q;

`ifndef SYNTHESIS
	a_csum_range: assert property (@(posedge clk) disable iff (!arst_n)
		checksum_valid_q |-> checksum_q != 16'hFFFF)
		else $error("checksum holds an unreduced value");

	a_start_pos: assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_first_q |-> (position_q == POS_INIT && older_q == TERM_INIT))
		else $error("start state not restored");

	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !awaiting_first_q && !final_s1) |=> older_q == $past(newer_q))
		else $error("older term did not take the newer term");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && final_s1) |=> (checksum_valid_q && checksum_q == $past(next_term)))
		else $error("checksum not loaded on the final byte");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(checksum_valid_q && !checksum_ready && valid_s1 && final_s1) |-> !advance)
		else $error("pending checksum overwritten");
`endif

endmodule

`default_nettype wire

[tb/sv/tcs_checksum_monitor.sv]
`timescale 1ns / 100ps

module tcs_checksum_monitor (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 data_valid,
	input  wire                 data_ready,
	input  wire tcs_pkg::byte_t data_byte,
	input  wire                 final_byte,
	input  wire                 checksum_valid,
	input  wire                 checksum_ready,
	input  wire tcs_pkg::term_t checksum,
	output int                  mismatches,
	output int                  sums_owed
);
	import tcs_pkg::*;

	localparam longint unsigned MODULUS = 65535;

	term_t older_term_q;
	term_t newer_term_q;
	pos_t  byte_index;
	logic  message_start;
	term_t next_value;
	term_t wanted_sum;
	term_t expected_sums[$];

	function automatic term_t advance_term(byte_t b, pos_t i, term_t older, term_t newer);
		longint unsigned alpha;
		longint unsigned beta;
		longint unsigned prod;
		longint unsigned sub;
		longint unsigned diff;
		alpha = (64'(i) * 17) % 256;
		beta  = (64'(i) * 31) % 256;
		prod  = (64'(b) + alpha) * 64'(newer);
		sub   = beta * 64'(older);
		if (prod >= sub) begin
			return term_t'((prod - sub) % MODULUS);
		end
		// A negative difference wraps through 2^64, which is 1 modulo 65535.
		diff = (sub - prod) % MODULUS;
		return term_t'((1 + MODULUS - diff) % MODULUS);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			older_term_q  = TERM_INIT;
			newer_term_q  = TERM_INIT;
			byte_index    = POS_INIT;
			message_start = 1'b1;
			mismatches    = 0;
			expected_sums.delete();
			sums_owed    <= 0;
		end else begin
			if (data_valid && data_ready) begin
				if (message_start) begin
					older_term_q  = TERM_INIT;
					newer_term_q  = term_t'(data_byte) + FIRST_OFFSET;
					byte_index    = POS_SECOND;
					message_start = 1'b0;
				end else begin
					next_value   = advance_term(data_byte, byte_index, older_term_q, newer_term_q);
					older_term_q = newer_term_q;
					newer_term_q = next_value;
					byte_index   = byte_index + 8'd1;
				end
				if (final_byte) begin
					expected_sums.push_back(newer_term_q);
					older_term_q  = TERM_INIT;
					newer_term_q  = TERM_INIT;
					byte_index    = POS_INIT;
					message_start = 1'b1;
				end
			end
			if (checksum_valid && checksum_ready) begin
				if (expected_sums.size() == 0) begin
					$error("checksum: expected none, actual 0x%04h", checksum);
					mismatches++;
				end else begin
					wanted_sum = expected_sums.pop_front();
					if (checksum !== wanted_sum) begin
						$error("checksum: expected 0x%04h, actual 0x%04h", wanted_sum, checksum);
						mismatches++;
					end
				end
			end
			sums_owed <= expected_sums.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import tcs_pkg::*;

	localparam int SINK_HOLD   = 150;
	localparam int IDLE_LIMIT  = 2000;
	localparam int ITEM_TARGET = 650;

	logic  clk            = 1'b0;
	logic  arst_n         = 1'b0;
	logic  data_valid     = 1'b0;
	logic  data_ready;
	byte_t data_byte      = '0;
	logic  final_byte     = 1'b0;
	logic  checksum_valid;
	logic  checksum_ready = 1'b0;
	term_t checksum;
	int    mismatches;
	int    sums_owed;
	int    bytes_sent     = 0;
	int    holds_asked    = 0;
	int    holds_done     = 0;
	int    idle_cycles    = 0;

	always #1 clk = ~clk;

	three_term_recurrence_checksum_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_valid    (data_valid),
		.data_ready    (data_ready),
		.data_byte     (data_byte),
		.final_byte    (final_byte),
		.checksum_valid(checksum_valid),
		.checksum_ready(checksum_ready),
		.checksum      (checksum)
	);

	tcs_checksum_monitor monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_valid    (data_valid),
		.data_ready    (data_ready),
		.data_byte     (data_byte),
		.final_byte    (final_byte),
		.checksum_valid(checksum_valid),
		.checksum_ready(checksum_ready),
		.checksum      (checksum),
		.mismatches    (mismatches),
		.sums_owed     (sums_owed)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 10);
	endfunction

	function automatic byte_t pick_byte();
		int r;
		r = $urandom_range(9);
		if (r == 0) begin
			return 8'h00;
		end
		if (r == 1) begin
			return 8'hFF;
		end
		return byte_t'($urandom);
	endfunction

	task automatic push_byte(input byte_t b, input logic last, input bit steady);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte  <= b;
		final_byte <= last;
		do @(posedge clk); while (!data_ready);
		bytes_sent++;
	endtask

	task automatic push_message(input int len, input bit steady);
		for (int k = 0; k < len; k++) begin
			push_byte(pick_byte(), k == len - 1, steady);
		end
	endtask

	task automatic drain_checksums();
		data_valid <= 1'b0;
		do @(posedge clk); while (sums_owed != 0);
	endtask

	initial begin : sink
		int span;
		forever begin
			if (holds_done != holds_asked) begin
				holds_done++;
				checksum_ready <= 1'b0;
				repeat (SINK_HOLD) @(posedge clk);
			end else begin
				checksum_ready <= 1'b1;
				repeat ($urandom_range(30, 1)) @(posedge clk);
				span = pick_gap();
				if (span > 0) begin
					checksum_ready <= 1'b0;
					repeat (span) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (data_valid && data_ready) || (checksum_valid && checksum_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		int  r;
		bit  long_done;
		bit  hold_done;
		long_done = 1'b0;
		hold_done = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_byte(8'h00, 1'b1, 1'b0);
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);
		push_byte(8'h00, 1'b1, 1'b1);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte(8'h55, 1'b0, 1'b1);
		push_byte(8'hAA, 1'b0, 1'b1);
		push_byte(8'h0F, 1'b0, 1'b1);
		push_byte(8'hF0, 1'b1, 1'b1);
		push_message(12, 1'b0);
		drain_checksums();

		while (bytes_sent < ITEM_TARGET) begin
			r = $urandom_range(99);
			if (!hold_done && bytes_sent > 150) begin
				hold_done = 1'b1;
				holds_asked++;
				while (holds_done != holds_asked) @(posedge clk);
				for (int k = 0; k < 16; k++) begin
					push_byte(pick_byte(), 1'b1, 1'b1);
				end
				drain_checksums();
			end else if (!long_done && bytes_sent > 250) begin
				// Long enough for the byte position to wrap past 255.
				long_done = 1'b1;
				push_message(300, $urandom_range(1) != 0);
			end else if (r < 70) begin
				push_message($urandom_range(6, 1), $urandom_range(3) == 0);
			end else if (r < 95) begin
				push_message($urandom_range(24, 7), $urandom_range(3) == 0);
			end else begin
				push_message($urandom_range(60, 25), $urandom_range(3) == 0);
			end
		end

		drain_checksums();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && sums_owed == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[files.f]
hdl/tcs_pkg.sv
hdl/tcs_term_unit.sv
hdl/three_term_recurrence_checksum_core.sv
tb/sv/tcs_checksum_monitor.sv
tb/sv/tb_top.sv
